// ===== hw/rtl/gsbp_pkg.sv =====
// shared types, constants and helper functions of the gaussian-sum bond pair kernel
package gsbp_pkg;

  localparam int MAX_TERMS = 6;
  localparam int TERM_REGS = 6;
  localparam int FRAC_BITS = 16;

  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_TERM0 = 3'd1;

  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [63:0] EV_CAP    = 64'd8 << 24;
  localparam logic [63:0] CAP62     = 64'd1 << 62;
  localparam logic [63:0] CAP32     = 64'hFFFF_FFFF;

  localparam int SH_EV  = 13;
  localparam int SH_W   = 5;
  localparam int SH_INV = 32 + FRAC_BITS;
  localparam int SH_Q   = 32;
  localparam int SH_U   = 30;
  localparam int D24_SH = 24 - FRAC_BITS;
  localparam int FS_SH  = 61 - FRAC_BITS;
  localparam int EN_SH  = 54 - FRAC_BITS;
  localparam logic signed [31:0] DLOG_OFS = 32'((30 - 2 * FRAC_BITS) * (1 << 24));

  // datapath operations
  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_SQ        = 5'd2;
  localparam logic [4:0] OP_INVAL     = 5'd3;
  localparam logic [4:0] OP_SQRT_INIT = 5'd4;
  localparam logic [4:0] OP_SQRT_STEP = 5'd5;
  localparam logic [4:0] OP_TERM_LD   = 5'd6;
  localparam logic [4:0] OP_DIV_INIT  = 5'd7;
  localparam logic [4:0] OP_DIV_STEP  = 5'd8;
  localparam logic [4:0] OP_EV_ST     = 5'd9;
  localparam logic [4:0] OP_EXP_Y     = 5'd10;
  localparam logic [4:0] OP_EXP_T     = 5'd11;
  localparam logic [4:0] OP_EXP_A     = 5'd12;
  localparam logic [4:0] OP_EXP_B     = 5'd13;
  localparam logic [4:0] OP_EXP_G     = 5'd14;
  localparam logic [4:0] OP_AG        = 5'd15;
  localparam logic [4:0] OP_TACC      = 5'd16;
  localparam logic [4:0] OP_INV_ST    = 5'd17;
  localparam logic [4:0] OP_Q_ST      = 5'd18;
  localparam logic [4:0] OP_MS        = 5'd19;
  localparam logic [4:0] OP_F_ST      = 5'd20;
  localparam logic [4:0] OP_LG_INIT   = 5'd21;
  localparam logic [4:0] OP_LG_SHIFT  = 5'd22;
  localparam logic [4:0] OP_LG_M      = 5'd23;
  localparam logic [4:0] OP_LG_SQ     = 5'd24;
  localparam logic [4:0] OP_LG_ST     = 5'd25;
  localparam logic [4:0] OP_ENERGY    = 5'd26;

  // divider operand sets
  localparam logic [2:0] DS_EV  = 3'd0;
  localparam logic [2:0] DS_W   = 3'd1;
  localparam logic [2:0] DS_INV = 3'd2;
  localparam logic [2:0] DS_Q   = 3'd3;
  localparam logic [2:0] DS_U   = 3'd4;

  typedef struct packed {
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
    logic signed [31:0] dist_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] energy;
    logic               invalid;
  } out_t;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] dsel;
    logic [2:0] term;
    logic [1:0] axis;
    logic [4:0] step;
    logic       lsel;
  } cmd_t;

  typedef struct packed {
    logic       r2_zero;
    logic       c_zero;
    logic       ev_sat;
    logic       exp_big;
    logic       g_zero;
    logic       prob_zero;
    logic       norm_top;
    logic [2:0] term_cnt;
  } stat_t;

  function automatic logic [6:0] div_len(input logic [2:0] dsel);
    logic [6:0] len;
    unique case (dsel)
      DS_EV:   len = 7'(64 + SH_EV);
      DS_W:    len = 7'(64 + SH_W);
      DS_INV:  len = 7'(64 + SH_INV);
      DS_Q:    len = 7'(64 + SH_Q);
      DS_U:    len = 7'(64 + SH_U);
      default: len = 7'd1;
    endcase
    return len;
  endfunction

  // ceil(2^34 / k), exact floor division by k for values below 2^30
  function automatic logic [34:0] recip(input logic [3:0] k);
    logic [34:0] m;
    case (k)
      4'd1:    m = 35'd17179869184;
      4'd2:    m = 35'd8589934592;
      4'd3:    m = 35'd5726623062;
      4'd4:    m = 35'd4294967296;
      4'd5:    m = 35'd3435973837;
      4'd6:    m = 35'd2863311531;
      4'd7:    m = 35'd2454267027;
      4'd8:    m = 35'd2147483648;
      4'd9:    m = 35'd1908874354;
      4'd10:   m = 35'd1717986919;
      4'd11:   m = 35'd1561806290;
      4'd12:   m = 35'd1431655766;
      default: m = 35'd0;
    endcase
    return m;
  endfunction

  function automatic logic signed [31:0] sat32(input logic neg, input logic [32:0] mag);
    logic signed [31:0] v;
    if (neg) begin
      v = (mag >= 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(-mag[31:0]);
    end else begin
      v = (mag > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/gsbp_ctrl.sv =====
// sequencer that steps the datapath through one bond evaluation
module gsbp_ctrl
  import gsbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output logic  done,
  output cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SQ    = 5'd1;
  localparam logic [4:0] ST_R2CHK = 5'd2;
  localparam logic [4:0] ST_SQRT  = 5'd3;
  localparam logic [4:0] ST_TSEL  = 5'd4;
  localparam logic [4:0] ST_TCHK  = 5'd5;
  localparam logic [4:0] ST_DIV   = 5'd6;
  localparam logic [4:0] ST_EVST  = 5'd7;
  localparam logic [4:0] ST_EXP1  = 5'd8;
  localparam logic [4:0] ST_EXP2  = 5'd9;
  localparam logic [4:0] ST_EXP3  = 5'd10;
  localparam logic [4:0] ST_ETA   = 5'd11;
  localparam logic [4:0] ST_ETB   = 5'd12;
  localparam logic [4:0] ST_EXPF  = 5'd13;
  localparam logic [4:0] ST_GCHK  = 5'd14;
  localparam logic [4:0] ST_WINIT = 5'd15;
  localparam logic [4:0] ST_TACC  = 5'd16;
  localparam logic [4:0] ST_PCHK  = 5'd17;
  localparam logic [4:0] ST_INVST = 5'd18;
  localparam logic [4:0] ST_QINIT = 5'd19;
  localparam logic [4:0] ST_QST   = 5'd20;
  localparam logic [4:0] ST_UINIT = 5'd21;
  localparam logic [4:0] ST_MS    = 5'd22;
  localparam logic [4:0] ST_FST   = 5'd23;
  localparam logic [4:0] ST_LGI   = 5'd24;
  localparam logic [4:0] ST_LGN   = 5'd25;
  localparam logic [4:0] ST_LGS   = 5'd26;
  localparam logic [4:0] ST_LGST  = 5'd27;
  localparam logic [4:0] ST_EN    = 5'd28;
  localparam logic [4:0] ST_DONE  = 5'd29;

  logic [4:0] state, state_next;
  logic [6:0] cnt, cnt_next;
  logic [2:0] ti, ti_next;
  logic [1:0] axis, axis_next;
  logic       lsel, lsel_next;
  logic [2:0] dsel, dsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ti    <= '0;
      axis  <= '0;
      lsel  <= 1'b0;
      dsel  <= DS_EV;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ti    <= ti_next;
      axis  <= axis_next;
      lsel  <= lsel_next;
      dsel  <= dsel_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ti_next    = ti;
    axis_next  = axis;
    lsel_next  = lsel;
    dsel_next  = dsel;
    cmd.op     = OP_NOP;
    cmd.dsel   = dsel;
    cmd.term   = ti;
    cmd.axis   = axis;
    cmd.step   = cnt[4:0];
    cmd.lsel   = lsel;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          cnt_next   = '0;
          ti_next    = '0;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.op   = OP_SQ;
        cmd.axis = cnt[1:0];
        if (cnt == 7'd2) begin
          state_next = ST_R2CHK;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      ST_R2CHK: begin
        if (stat.r2_zero) begin
          cmd.op     = OP_INVAL;
          state_next = ST_DONE;
        end else begin
          cmd.op     = OP_SQRT_INIT;
          cnt_next   = '0;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt == 7'd31) begin
          state_next = ST_TSEL;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      ST_TSEL: begin
        if (ti == stat.term_cnt) begin
          state_next = ST_PCHK;
        end else begin
          cmd.op     = OP_TERM_LD;
          state_next = ST_TCHK;
        end
      end
      ST_TCHK: begin
        if (stat.c_zero) begin
          ti_next    = ti + 3'd1;
          state_next = ST_TSEL;
        end else begin
          cmd.op     = OP_DIV_INIT;
          cmd.dsel   = DS_EV;
          dsel_next  = DS_EV;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == 7'(div_len(dsel) - 7'd1)) begin
          cnt_next = '0;
          unique case (dsel)
            DS_EV:   state_next = ST_EVST;
            DS_W:    state_next = ST_TACC;
            DS_INV:  state_next = ST_INVST;
            DS_Q:    state_next = ST_QST;
            DS_U:    state_next = ST_MS;
            default: state_next = ST_IDLE;
          endcase
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      ST_EVST: begin
        cmd.op     = OP_EV_ST;
        state_next = ST_EXP1;
      end
      ST_EXP1: begin
        if (stat.ev_sat) begin
          ti_next    = ti + 3'd1;
          state_next = ST_TSEL;
        end else begin
          cmd.op     = OP_EXP_Y;
          state_next = ST_EXP2;
        end
      end
      ST_EXP2: begin
        cmd.op     = OP_EXP_T;
        state_next = ST_EXP3;
      end
      ST_EXP3: begin
        if (stat.exp_big) begin
          ti_next    = ti + 3'd1;
          state_next = ST_TSEL;
        end else begin
          cnt_next   = 7'd1;
          state_next = ST_ETA;
        end
      end
      ST_ETA: begin
        cmd.op     = OP_EXP_A;
        state_next = ST_ETB;
      end
      ST_ETB: begin
        cmd.op = OP_EXP_B;
        if (cnt == 7'd12) begin
          state_next = ST_EXPF;
        end else begin
          cnt_next   = cnt + 7'd1;
          state_next = ST_ETA;
        end
      end
      ST_EXPF: begin
        cmd.op     = OP_EXP_G;
        state_next = ST_GCHK;
      end
      ST_GCHK: begin
        if (stat.g_zero) begin
          ti_next    = ti + 3'd1;
          state_next = ST_TSEL;
        end else begin
          cmd.op     = OP_AG;
          state_next = ST_WINIT;
        end
      end
      ST_WINIT: begin
        cmd.op     = OP_DIV_INIT;
        cmd.dsel   = DS_W;
        dsel_next  = DS_W;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_TACC: begin
        cmd.op     = OP_TACC;
        ti_next    = ti + 3'd1;
        state_next = ST_TSEL;
      end
      ST_PCHK: begin
        if (stat.prob_zero) begin
          cmd.op     = OP_INVAL;
          state_next = ST_DONE;
        end else begin
          cmd.op     = OP_DIV_INIT;
          cmd.dsel   = DS_INV;
          dsel_next  = DS_INV;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_INVST: begin
        cmd.op     = OP_INV_ST;
        state_next = ST_QINIT;
      end
      ST_QINIT: begin
        cmd.op     = OP_DIV_INIT;
        cmd.dsel   = DS_Q;
        dsel_next  = DS_Q;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_QST: begin
        cmd.op     = OP_Q_ST;
        axis_next  = '0;
        state_next = ST_UINIT;
      end
      ST_UINIT: begin
        cmd.op     = OP_DIV_INIT;
        cmd.dsel   = DS_U;
        dsel_next  = DS_U;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_MS: begin
        cmd.op = OP_MS;
        if (cnt == 7'd3) begin
          state_next = ST_FST;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      ST_FST: begin
        cmd.op = OP_F_ST;
        if (axis == 2'd2) begin
          lsel_next  = 1'b0;
          state_next = ST_LGI;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_UINIT;
        end
      end
      ST_LGI: begin
        cmd.op     = OP_LG_INIT;
        state_next = ST_LGN;
      end
      ST_LGN: begin
        if (stat.norm_top) begin
          cmd.op     = OP_LG_M;
          cnt_next   = '0;
          state_next = ST_LGS;
        end else begin
          cmd.op = OP_LG_SHIFT;
        end
      end
      ST_LGS: begin
        cmd.op = OP_LG_SQ;
        if (cnt == 7'd23) begin
          state_next = ST_LGST;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      ST_LGST: begin
        cmd.op = OP_LG_ST;
        if (!lsel) begin
          lsel_next  = 1'b1;
          state_next = ST_LGI;
        end else begin
          state_next = ST_EN;
        end
      end
      ST_EN: begin
        cmd.op     = OP_ENERGY;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

// ===== hw/rtl/gsbp_dpath.sv =====
// datapath: term registers, shared multiplier, restoring divider, sqrt and log2 steps
module gsbp_dpath
  import gsbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data,
  input  in_t         item,
  input  cmd_t        cmd,
  output stat_t       stat,
  output out_t        result
);

  logic [2:0]  term_count;
  logic [62:0] terms [TERM_REGS];

  logic [31:0]  mag [3];
  logic [2:0]   neg;
  logic [63:0]  r2;
  logic [63:0]  sqn, sqr, sqb;
  logic [20:0]  a, c;
  logic         uneg;
  logic [39:0]  umag;
  logic [63:0]  dnum, dden, dcap, drem, dq;
  logic         dovf;
  logic [27:0]  ev;
  logic [30:0]  x;
  logic [31:0]  y;
  logic [7:0]   en;
  logic [29:0]  t;
  logic [30:0]  term, pm, g;
  logic signed [32:0] esum;
  logic [51:0]  ag;
  logic [37:0]  prob;
  logic signed [53:0] apart;
  logic [62:0]  inv, smag;
  logic         sneg;
  logic [127:0] acc;
  logic [63:0]  norm;
  logic [5:0]   lk;
  logic [30:0]  lm;
  logic [29:0]  lres, lgr, lgp;

  logic [31:0]  r;
  logic [39:0]  d24;
  logic [62:0]  tw;
  logic [39:0]  b24;
  logic [63:0]  divres;
  logic [63:0]  div_n, div_d, div_cap;
  logic [64:0]  rem2;
  logic         ge;
  logic [63:0]  sq_try;
  logic [53:0]  apart_mag;
  logic signed [64:0] s_val;
  logic signed [31:0] dlog;
  logic [30:0]  dlog_mag;
  logic [127:0] acc_sh;
  logic [31:0]  fmag;
  logic [34:0]  mul_a, mul_b;
  logic [69:0]  mul_p;
  logic [127:0] pp;
  logic [31:0]  lsq;
  logic [2:0]   cnt_clamp;

  assign r      = sqr[31:0];
  assign d24    = 40'(r) << D24_SH;
  assign tw     = terms[cmd.term];
  assign b24    = {8'd0, tw[41:21], 11'd0};
  assign divres = (dovf || (dq > dcap)) ? dcap : dq;
  assign rem2   = {drem, dnum[63]};
  assign ge     = rem2 >= {1'b0, dden};
  assign sq_try = sqr + sqb;
  assign apart_mag = apart[53] ? 54'(-apart) : 54'(apart);

  always_comb begin
    if (apart[53]) begin
      s_val = $signed({2'b0, inv}) - $signed({2'b0, divres[62:0]});
    end else begin
      s_val = $signed({2'b0, inv}) + $signed({2'b0, divres[62:0]});
    end
  end

  assign dlog     = $signed({2'b0, lgr}) - $signed({2'b0, lgp}) + DLOG_OFS;
  assign dlog_mag = dlog[31] ? 31'(-dlog) : dlog[30:0];
  assign acc_sh   = acc >> FS_SH;
  assign fmag     = (acc_sh > 128'h8000_0000) ? 32'h8000_0000 : acc_sh[31:0];
  assign lsq      = mul_p[61:30];

  always_comb begin
    unique case (cmd.dsel)
      DS_EV: begin
        div_n = 64'(umag); div_d = 64'(c); div_cap = EV_CAP;
      end
      DS_W: begin
        div_n = 64'(ev); div_d = 64'(c); div_cap = CAP32;
      end
      DS_INV: begin
        div_n = 64'd1; div_d = 64'(r); div_cap = CAP62;
      end
      DS_Q: begin
        div_n = 64'(apart_mag); div_d = 64'(prob); div_cap = CAP62;
      end
      DS_U: begin
        div_n = 64'(mag[cmd.axis]); div_d = 64'(r); div_cap = CAP62;
      end
      default: begin
        div_n = '0; div_d = 64'd1; div_cap = '0;
      end
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ: begin
        mul_a = 35'(mag[cmd.axis]); mul_b = 35'(mag[cmd.axis]);
      end
      OP_EV_ST: begin
        mul_a = 35'(divres[27:0]); mul_b = 35'(divres[27:0]);
      end
      OP_EXP_Y: begin
        mul_a = 35'(x); mul_b = 35'(LOG2E_Q24);
      end
      OP_EXP_T: begin
        mul_a = 35'(y[23:0]); mul_b = 35'(LN2_Q30);
      end
      OP_EXP_A: begin
        mul_a = 35'(term); mul_b = 35'(t);
      end
      OP_EXP_B: begin
        mul_a = 35'(pm); mul_b = recip(cmd.step[3:0]);
      end
      OP_AG: begin
        mul_a = 35'(a); mul_b = 35'(g);
      end
      OP_TACC: begin
        mul_a = 35'(ag[50:19]); mul_b = 35'(divres[31:0]);
      end
      OP_MS: begin
        mul_a = cmd.step[0] ? 35'(smag[62:32]) : 35'(smag[31:0]);
        mul_b = cmd.step[1] ? 35'(divres[62:32]) : 35'(divres[31:0]);
      end
      OP_LG_SQ: begin
        mul_a = 35'(lm); mul_b = 35'(lm);
      end
      OP_ENERGY: begin
        mul_a = 35'(dlog_mag); mul_b = 35'(LN2_Q30);
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign pp    = 128'(mul_p) << (7'(cmd.step[0]) * 7'd32 + 7'(cmd.step[1]) * 7'd32);

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
      for (int i = 0; i < TERM_REGS; i++) begin
        terms[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_COUNT) begin
        term_count <= cfg_data[2:0];
      end else if (cfg_index >= REG_TERM0 && cfg_index < 3'(REG_TERM0 + TERM_REGS)) begin
        terms[3'(cfg_index - REG_TERM0)] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        neg    <= {item.dist_z[31], item.dist_y[31], item.dist_x[31]};
        mag[0] <= item.dist_x[31] ? -item.dist_x : item.dist_x;
        mag[1] <= item.dist_y[31] ? -item.dist_y : item.dist_y;
        mag[2] <= item.dist_z[31] ? -item.dist_z : item.dist_z;
        r2     <= '0;
        prob   <= '0;
        apart  <= '0;
        result.invalid <= 1'b0;
      end
      OP_SQ: begin
        r2 <= r2 + mul_p[63:0];
      end
      OP_INVAL: begin
        result.force_x <= '0;
        result.force_y <= '0;
        result.force_z <= '0;
        result.energy  <= '0;
        result.invalid <= 1'b1;
      end
      OP_SQRT_INIT: begin
        sqn <= r2;
        sqr <= '0;
        sqb <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sqn >= sq_try) begin
          sqn <= sqn - sq_try;
          sqr <= (sqr >> 1) + sqb;
        end else begin
          sqr <= sqr >> 1;
        end
        sqb <= sqb >> 2;
      end
      OP_TERM_LD: begin
        a    <= tw[62:42];
        c    <= tw[20:0];
        uneg <= b24 > d24;
        umag <= (b24 > d24) ? b24 - d24 : d24 - b24;
      end
      OP_DIV_INIT: begin
        dnum <= div_n;
        dden <= div_d;
        dcap <= div_cap;
        drem <= '0;
        dq   <= '0;
        dovf <= 1'b0;
      end
      OP_DIV_STEP: begin
        dnum <= dnum << 1;
        drem <= ge ? 64'(rem2 - {1'b0, dden}) : rem2[63:0];
        dovf <= dovf | dq[63];
        dq   <= {dq[62:0], ge};
      end
      OP_EV_ST: begin
        ev <= divres[27:0];
        x  <= mul_p[54:24];
      end
      OP_EXP_Y: begin
        y <= mul_p[55:24];
      end
      OP_EXP_T: begin
        en   <= y[31:24];
        t    <= mul_p[53:24];
        term <= 31'd1 << 30;
        esum <= 33'sd1 << 30;
      end
      OP_EXP_A: begin
        pm <= mul_p[60:30];
      end
      OP_EXP_B: begin
        term <= mul_p[64:34];
        if (cmd.step[0]) begin
          esum <= esum - $signed({2'b0, mul_p[64:34]});
        end else begin
          esum <= esum + $signed({2'b0, mul_p[64:34]});
        end
      end
      OP_EXP_G: begin
        g <= esum[32] ? 31'd0 : (esum[30:0] >> en[4:0]);
      end
      OP_AG: begin
        ag   <= mul_p[51:0];
        prob <= prob + 38'(mul_p[51:17]);
      end
      OP_TACC: begin
        if (uneg) begin
          apart <= apart - $signed({4'b0, mul_p[63:14]});
        end else begin
          apart <= apart + $signed({4'b0, mul_p[63:14]});
        end
      end
      OP_INV_ST: begin
        inv <= divres[62:0];
      end
      OP_Q_ST: begin
        sneg <= s_val[64];
        smag <= s_val[64] ? 63'(-s_val) : s_val[62:0];
      end
      OP_MS: begin
        acc <= ((cmd.step[1:0] == 2'd0) ? 128'd0 : acc) + pp;
      end
      OP_F_ST: begin
        unique case (cmd.axis)
          2'd0:    result.force_x <= sat32(sneg == neg[0], 33'(fmag));
          2'd1:    result.force_y <= sat32(sneg == neg[1], 33'(fmag));
          2'd2:    result.force_z <= sat32(sneg == neg[2], 33'(fmag));
          default: result.force_x <= result.force_x;
        endcase
      end
      OP_LG_INIT: begin
        norm <= cmd.lsel ? 64'(prob) : r2;
        lk   <= 6'd63;
      end
      OP_LG_SHIFT: begin
        norm <= norm << 1;
        lk   <= lk - 6'd1;
      end
      OP_LG_M: begin
        lm   <= norm[63:33];
        lres <= {lk, 24'd0};
      end
      OP_LG_SQ: begin
        if (lsq[31]) begin
          lm <= lsq[31:1];
          lres[5'd23 - cmd.step] <= 1'b1;
        end else begin
          lm <= lsq[30:0];
        end
      end
      OP_LG_ST: begin
        if (cmd.lsel) begin
          lgp <= lres;
        end else begin
          lgr <= lres;
        end
      end
      OP_ENERGY: begin
        result.energy <= sat32(dlog[31], 33'(mul_p >> EN_SH));
      end
      default: begin
      end
    endcase
  end

  assign cnt_clamp = (term_count > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : term_count;

  assign stat.r2_zero   = (r2 == '0);
  assign stat.c_zero    = (c == '0);
  assign stat.ev_sat    = (64'(ev) >= EV_CAP);
  assign stat.exp_big   = (en > 8'd30);
  assign stat.g_zero    = (g == '0);
  assign stat.prob_zero = (prob == '0);
  assign stat.norm_top  = norm[63];
  assign stat.term_cnt  = cnt_clamp;

endmodule

// ===== hw/rtl/gaussian_sum_bond_pair_kernel.sv =====
// top level of the gaussian-sum bond pair kernel: sequencer plus datapath
// One beat in, one beat out. An item is taken when start is high and busy is low;
// busy then stays high until the result beat, which is on result for exactly one
// cycle with done high and cannot be held off. Latency is shortest for zero
// distance and grows with the number of terms in use; most of it comes from
// the single restoring divider, one quotient bit per cycle (up to two divisions
// per active term, one each for 1/r and A/P, one per axis), plus the sqrt steps,
// the exp series of each term and two log2 passes.
// The next item can be taken in the cycle after done.
module gaussian_sum_bond_pair_kernel
  import gsbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         item,
  output logic        done,
  output out_t        result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  gsbp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  gsbp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat outside a busy interval");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted beat did not start a computation");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("sequencer not idle after result beat");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.invalid |-> result.energy == 0 && result.force_x == 0 &&
                               result.force_y == 0 && result.force_z == 0)
    else $error("invalid result carries nonzero values");

endmodule
